### sv/gf2mi_pkg.sv
// Shared sizes, result codes, FSM state type and control structs for the
// GF(2^m) extended-Euclid inverter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gf2mi_pkg;

    // Field element width and bound on division rounds
    localparam int FIELD_BITS = 10;
    localparam int MAX_STEPS  = 20;

    // Remainder width (modulus has one more bit than an element)
    localparam int RW = FIELD_BITS + 1;
    // Coefficient width, with headroom for the left-aligned copy
    localparam int TW = 2 * RW;
    // Bit position / shift count width
    localparam int PW = $clog2(RW);
    // Division round counter width
    localparam int SW = $clog2(MAX_STEPS + 1);

    // Modulus after reset: x^10 + x^3 + 1
    localparam logic [RW-1:0] MOD_RESET = RW'(1033);

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_NOINV = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_DIV,
        S_NEXT,
        S_FINISH
    } t_state;

    // Sequencer to datapath
    typedef struct packed {
        logic load;
        logic norm;
        logic div;
        logic advance;
    } t_dp_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic                  den_top;
        logic                  k_zero;
        logic                  rem_zero;
        logic                  rcur_one;
        logic [FIELD_BITS-1:0] inv;
    } t_dp_stat;

endpackage

`default_nettype wire

### sv/gf2m_inverse_euclid_core.sv
// Top level: APB modulus register, sequencer and output word register of the
// GF(2^m) inverter. Depends on gf2mi_pkg and gf2mi_datapath.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_operand
//   output    out        o_out_valid / i_out_stall  o_inverse, o_status
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One word at a time. Each division round runs in the shared shift-xor unit (align,
// one quotient bit per cycle, update); a word takes as many rounds as its
// remainder sequence needs, at most MAX_STEPS. A zero operand or a modulus below
// two skips the division rounds.
// Reset (synchronous, active low) restores modulus 1033 and empties the output.
// A stalled output holds its word; the next word is taken once the previous
// result has moved into the output register.
`timescale 1ns / 1ps
`default_nettype none

module gf2m_inverse_euclid_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // input words
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire [gf2mi_pkg::FIELD_BITS-1:0] i_operand,
    // result words
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output logic [gf2mi_pkg::FIELD_BITS-1:0] o_inverse,
    output logic [1:0]                      o_status,
    // configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [2:0]                       paddr,
    input  wire [31:0]                      pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import gf2mi_pkg::*;

    t_state                r_state, n_state;
    logic [RW-1:0]         r_modulus;
    logic [SW-1:0]         r_steps, n_steps;
    logic [FIELD_BITS-1:0] r_res_inv, n_res_inv;
    logic [1:0]            r_res_st,  n_res_st;
    logic                  r_out_valid, n_out_valid;
    logic [FIELD_BITS-1:0] r_out_inv,   n_out_inv;
    logic [1:0]            r_out_st,    n_out_st;

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;
    logic     in_acc;
    logic     out_free;

    gf2mi_datapath u_dp (
        .i_clk     (i_clk),
        .i_ctrl    (dp_ctrl),
        .i_modulus (r_modulus),
        .i_operand (i_operand),
        .o_stat    (dp_stat)
    );

    // Configuration register
    assign pready = 1'b1;
    assign prdata = 32'(r_modulus);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_modulus <= pwdata[RW-1:0];
        end
    end

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and result bookkeeping
    always_comb begin
        n_state   = r_state;
        n_steps   = r_steps;
        n_res_inv = r_res_inv;
        n_res_st  = r_res_st;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_steps   = '0;
                    n_res_inv = '0;
                    if (i_operand == '0) begin
                        n_res_st = ST_ZERO;
                        n_state  = S_FINISH;
                    end else if (r_modulus < RW'(2)) begin
                        n_res_st = ST_NOINV;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (dp_stat.den_top) n_state = S_DIV;
            end
            S_DIV: begin
                if (dp_stat.k_zero) n_state = S_NEXT;
            end
            S_NEXT: begin
                if (dp_stat.rem_zero) begin
                    n_res_st  = dp_stat.rcur_one ? ST_OK : ST_NOINV;
                    n_res_inv = dp_stat.rcur_one ? dp_stat.inv : '0;
                    n_state   = S_FINISH;
                end else if (r_steps == SW'(MAX_STEPS - 1)) begin
                    n_res_st  = ST_NOINV;
                    n_res_inv = '0;
                    n_state   = S_FINISH;
                end else begin
                    n_steps = r_steps + SW'(1);
                    n_state = S_NORM;
                end
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall      = 1'b1;
        dp_ctrl.load    = 1'b0;
        dp_ctrl.norm    = 1'b0;
        dp_ctrl.div     = 1'b0;
        dp_ctrl.advance = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                dp_ctrl.load = in_acc;
            end
            S_NORM:   dp_ctrl.norm    = 1'b1;
            S_DIV:    dp_ctrl.div     = 1'b1;
            S_NEXT:   dp_ctrl.advance = !dp_stat.rem_zero;
            S_FINISH: ;
            default: ;
        endcase
    end

    // Output word register: load from a finished word, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_inv   = r_out_inv;
        n_out_st    = r_out_st;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (r_state == S_FINISH && out_free) begin
            n_out_valid = 1'b1;
            n_out_inv   = r_res_inv;
            n_out_st    = r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_inv <= n_res_inv;
        r_res_st  <= n_res_st;
        r_out_inv <= n_out_inv;
        r_out_st  <= n_out_st;
    end

    assign o_out_valid = r_out_valid;
    assign o_inverse   = r_out_inv;
    assign o_status    = r_out_st;

endmodule

`default_nettype wire

### sv/gf2mi_datapath.sv
// Bit-serial carry-less division and Bezout coefficient update.
// Depends on gf2mi_pkg; steered by the sequencer in the top level.
`timescale 1ns / 1ps
`default_nettype none

module gf2mi_datapath (
    input  wire                             i_clk,
    input  gf2mi_pkg::t_dp_ctrl             i_ctrl,
    input  wire [gf2mi_pkg::RW-1:0]         i_modulus,
    input  wire [gf2mi_pkg::FIELD_BITS-1:0] i_operand,
    output gf2mi_pkg::t_dp_stat             o_stat
);
    import gf2mi_pkg::*;

    logic [RW-1:0] r_num,   n_num;    // r_prev, becomes the remainder
    logic [RW-1:0] r_rcur,  n_rcur;   // divisor r_cur
    logic [RW-1:0] r_den,   n_den;    // divisor aligned to the tested bit
    logic [TW-1:0] r_tprev, n_tprev;
    logic [TW-1:0] r_tcur,  n_tcur;
    logic [TW-1:0] r_acc,   n_acc;    // t_prev xor q*t_cur, built up bitwise
    logic [TW-1:0] r_tsh,   n_tsh;    // t_cur aligned like r_den
    logic [PW-1:0] r_k,     n_k;      // alignment shift left to undo
    logic [PW-1:0] r_pos,   n_pos;    // bit of the remainder under test

    // Next values of the datapath registers
    always_comb begin
        n_num   = r_num;
        n_rcur  = r_rcur;
        n_den   = r_den;
        n_tprev = r_tprev;
        n_tcur  = r_tcur;
        n_acc   = r_acc;
        n_tsh   = r_tsh;
        n_k     = r_k;
        n_pos   = r_pos;
        if (i_ctrl.load) begin
            n_num   = i_modulus;
            n_rcur  = RW'(i_operand);
            n_den   = RW'(i_operand);
            n_tprev = '0;
            n_tcur  = TW'(1);
            n_acc   = '0;
            n_tsh   = TW'(1);
            n_k     = '0;
            n_pos   = PW'(RW - 1);
        end else if (i_ctrl.norm) begin
            // shift divisor up until its leading one sits in the top bit
            if (!r_den[RW-1]) begin
                n_den = {r_den[RW-2:0], 1'b0};
                n_tsh = {r_tsh[TW-2:0], 1'b0};
                n_k   = r_k + PW'(1);
            end
        end else if (i_ctrl.div) begin
            // one quotient bit: cancel the tested bit, then step down
            if (r_num[r_pos]) begin
                n_num = r_num ^ r_den;
                n_acc = r_acc ^ r_tsh;
            end
            if (r_k != '0) begin
                n_den = {1'b0, r_den[RW-1:1]};
                n_tsh = {1'b0, r_tsh[TW-1:1]};
                n_k   = r_k - PW'(1);
                n_pos = r_pos - PW'(1);
            end
        end else if (i_ctrl.advance) begin
            // rotate: (r_prev, r_cur) <- (r_cur, rem), (t_prev, t_cur) <- (t_cur, t_next)
            n_num   = r_rcur;
            n_rcur  = r_num;
            n_den   = r_num;
            n_tprev = r_tcur;
            n_tcur  = r_acc;
            n_acc   = r_tcur;
            n_tsh   = r_acc;
            n_k     = '0;
            n_pos   = PW'(RW - 1);
        end
    end

    // Payload registers, always loaded before use
    always_ff @(posedge i_clk) begin
        r_num   <= n_num;
        r_rcur  <= n_rcur;
        r_den   <= n_den;
        r_tprev <= n_tprev;
        r_tcur  <= n_tcur;
        r_acc   <= n_acc;
        r_tsh   <= n_tsh;
        r_k     <= n_k;
        r_pos   <= n_pos;
    end

    // Status back to the sequencer
    assign o_stat.den_top  = r_den[RW-1];
    assign o_stat.k_zero   = (r_k == '0);
    assign o_stat.rem_zero = (r_num == '0);
    assign o_stat.rcur_one = (r_rcur == RW'(1));
    assign o_stat.inv      = r_tcur[FIELD_BITS-1:0];

endmodule

`default_nettype wire

### sv/gf2mi_checker.sv
// Port-level checks of the GF(2^m) inverter, bound to its top level.
// Depends on gf2mi_pkg and gf2m_inverse_euclid_core.
`timescale 1ns / 1ps
`default_nettype none

module gf2mi_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             o_in_stall,
    input wire                             o_out_valid,
    input wire                             i_out_stall,
    input wire [gf2mi_pkg::FIELD_BITS-1:0] o_inverse,
    input wire [1:0]                       o_status
);
    import gf2mi_pkg::*;

    // one word in flight: a taken word closes the input for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after accepting a word");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_inverse) && $stable(o_status)))
        else $error("stalled result word changed");

    // failures carry a zero coefficient
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_inverse == '0))
        else $error("nonzero inverse with failure status");

    // an inverse is never zero, and no undefined status leaves
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == ST_OK && o_inverse != '0) ||
                         o_status == ST_ZERO || o_status == ST_NOINV))
        else $error("bad result word");

endmodule

bind gf2m_inverse_euclid_core gf2mi_checker u_gf2mi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_inverse   (o_inverse),
    .o_status    (o_status)
);

`default_nettype wire
